// ----- hw/rtl/integer_sort_engine_macros.svh -----
// assertion macros used by the checker file ise_checker.sv
`ifndef INTEGER_SORT_ENGINE_MACROS_SVH
`define INTEGER_SORT_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define ISE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sort engine check failed");

// next-cycle implication, disabled in reset
`define ISE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sort engine check failed");

`endif

// ----- hw/rtl/ise_pkg.sv -----
`default_nettype none

package ise_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctrl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic               occ;
        logic               gt;
        logic [VALUE_W-1:0] val;
    } t_cell_link;

endpackage

`default_nettype wire

// ----- hw/rtl/ise_cell.sv -----
`default_nettype none

module ise_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ise_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [ise_pkg::VALUE_W-1:0] i_value,
    input  wire ise_pkg::t_cell_link        i_prev,
    input  wire ise_pkg::t_cell_link        i_next,
    output ise_pkg::t_cell_link             o_link
);
    import ise_pkg::*;

    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] n_val;
    logic               r_occ;
    logic               n_occ;
    logic               gt;

    // stored value strictly above the incoming one; equal values stay put
    assign gt = r_occ && ($signed(r_val) > $signed(i_value));

    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        if (i_ctrl.shift) begin
            n_val = i_next.val;
            n_occ = i_next.occ;
        end else if (i_ctrl.ins) begin
            if (i_prev.gt) begin
                n_val = i_prev.val;
                n_occ = 1'b1;
            end else if ((gt || !r_occ) && i_prev.occ) begin
                n_val = i_value;
                n_occ = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link.occ = r_occ;
    assign o_link.gt  = gt;
    assign o_link.val = r_val;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_sort_engine.sv -----
// channel | valid   | ready   | payload
// input   | i_valid | o_ready | i_value, i_last
// output  | o_valid | i_ready | o_sorted_value, o_final_res, o_overflow
//
// loading: one input beat per cycle, each value placed in sorted position by the cell row
// after the beat with i_last, one result beat per cycle, shifted out of cell 0
// input is not taken while results drain; of n beats loaded, min(n, CAPACITY) drain
// a stalled output holds the cell row; input stalls simply leave it idle
// reset (synchronous, active low) empties every cell and returns to loading
`default_nettype none

module integer_sort_engine #(
    parameter int CAPACITY = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_value,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_sorted_value,
    output logic             o_final_res,
    output logic             o_overflow
);
    import ise_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic       r_dropped;
    logic       n_dropped;
    t_cell_ctrl ctrl;
    t_cell_link links [CAPACITY];
    t_cell_link head_link;
    t_cell_link tail_link;
    logic       in_beat;
    logic       out_beat;
    logic       full;

    // row is full once the top cell holds a value
    assign full     = links[CAPACITY-1].occ;
    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;

    // cell 0 sees an occupied, never-greater neighbor below it
    assign head_link = '{occ: 1'b1, gt: 1'b0, val: '0};
    // the top cell pulls in emptiness while draining
    assign tail_link = '{occ: 1'b0, gt: 1'b0, val: '0};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_beat && i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_beat && o_final_res) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs and cell commands
    always_comb begin
        o_ready    = 1'b0;
        o_valid    = 1'b0;
        ctrl.ins   = 1'b0;
        ctrl.shift = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_ready  = 1'b1;
                // values past capacity are dropped
                ctrl.ins = in_beat && !full;
            end
            ST_DRAIN: begin
                o_valid    = links[0].occ;
                ctrl.shift = out_beat;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // overflow sticks for the whole set, cleared with its final result
    always_comb begin
        n_dropped = r_dropped;
        if (in_beat && full) begin
            n_dropped = 1'b1;
        end else if (out_beat && o_final_res) begin
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    // the cell row, ascending from cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ise_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_value (i_value),
            .i_prev  ((g == 0) ? head_link : links[(g == 0) ? 0 : g - 1]),
            .i_next  ((g == CAPACITY - 1) ? tail_link
                                          : links[(g == CAPACITY - 1) ? g : g + 1]),
            .o_link  (links[g])
        );
    end

    // result comes straight from cell 0; last one when cell 1 is empty
    assign o_sorted_value = links[0].val;
    assign o_final_res    = !links[1].occ;
    assign o_overflow     = r_dropped;

endmodule

`default_nettype wire

// ----- hw/rtl/ise_checker.sv -----
`default_nettype none
`include "integer_sort_engine_macros.svh"

module ise_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_last,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_sorted_value,
    input wire logic        o_final_res,
    input wire logic        o_overflow
);

    // loading and draining never overlap
    `ISE_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_ready, !o_valid)

    // a closing input beat always yields a result next cycle
    `ISE_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n, i_valid && o_ready && i_last, o_valid)

    // after the final result the engine is back to loading
    `ISE_ASSERT_NEXT(a_final_ends, i_clk, i_rst_n, o_valid && i_ready && o_final_res,
                     !o_valid && o_ready)

    // overflow is a property of the whole set
    `ISE_ASSERT_NEXT(a_ovf_steady, i_clk, i_rst_n, o_valid && !o_final_res,
                     o_valid && (o_overflow == $past(o_overflow)))

    // a stalled result holds
    `ISE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
                     o_valid && $stable(o_sorted_value) && $stable(o_final_res))

endmodule

bind integer_sort_engine ise_checker u_ise_checker (.*);

`default_nettype wire
